### rtl/ttsr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the transient triggered slice repitch unit
package ttsr_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;
   localparam int THRESHOLD_W = 24;
   localparam int DECAY_W     = 31;
   localparam int RATIO_W     = 17;
   localparam int GAIN_W      = 16;
   localparam int CHUNK_W     = 15;
   localparam int ENV_W       = 32;
   localparam int FRAC_W      = 16;
   localparam int ENV_SHIFT   = 30;
   localparam int OUT_SHIFT   = 15;

   localparam logic [ENV_W-1:0]       ENV_ONE         = 32'h4000_0000;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 24'd2107124;
   localparam logic [DECAY_W-1:0]     DECAY_RESET     = 31'd1073741824;
   localparam logic [RATIO_W-1:0]     RATIO_RESET     = 17'd65536;
   localparam logic [GAIN_W-1:0]      WET_RESET       = 16'd16384;
   localparam logic [GAIN_W-1:0]      DRY_RESET       = 16'd0;
   localparam logic [CHUNK_W-1:0]     CHUNK_RESET     = 15'd5402;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD    = 3'd0,
      CSR_DECAY_FACTOR = 3'd1,
      CSR_PITCH_RATIO  = 3'd2,
      CSR_WET_GAIN     = 3'd3,
      CSR_DRY_GAIN     = 3'd4,
      CSR_MIN_CHUNK    = 3'd5,
      CSR_HIGH_QUALITY = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [THRESHOLD_W-1:0] threshold;
      logic [DECAY_W-1:0]     decay_factor;
      logic [RATIO_W-1:0]     pitch_ratio;
      logic [GAIN_W-1:0]      wet_gain;
      logic [GAIN_W-1:0]      dry_gain;
      logic [CHUNK_W-1:0]     min_chunk;
      logic                   high_quality;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_PUSH
   } f_state_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_WRITE,
      B_RD0,
      B_RD1,
      B_RD2,
      B_FADE,
      B_DIV,
      B_FDONE,
      B_INTERP,
      B_MIX,
      B_SCALE,
      B_OUT
   } b_state_type;

endpackage

### rtl/ttsr_front.sv
`timescale 1ns / 1ps
// Front end: accepts samples, detects transients, tracks position, index and envelope
module ttsr_front #(
   parameter int SLICE_DEPTH = 32768,
   parameter int FADE_LENGTH = 80,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ttsr_pkg::cfg_type             cfg,
   input  logic                          clr_busy,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  ttsr_pkg::q_status_type        q_stat,
   output logic                          q_push,
   output logic [2*SAMPLE_BITS+3*$clog2(SLICE_DEPTH)+3+16+32-1:0] q_data
);
   import ttsr_pkg::*;

   localparam int AW     = $clog2(SLICE_DEPTH);
   localparam int POS_W  = $clog2(SLICE_DEPTH + 2);
   localparam int CMP_W  = (POS_W > CHUNK_W) ? POS_W : CHUNK_W;
   localparam int SUM_W  = ((SAMPLE_BITS + 1 > THRESHOLD_W) ? SAMPLE_BITS + 1 : THRESHOLD_W) + 1;
   localparam int PROD_W = AW + RATIO_W;
   localparam int IDX_W  = AW + 1;
   localparam int EP_W   = ENV_W + DECAY_W;

   f_state_type state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] a_ff, b_ff;
   logic [AW-1:0]                 p_ff;
   logic                          active_ff;
   logic [ENV_W-1:0]              gbase_ff;
   logic [PROD_W-1:0]             prod_idx_ff;
   logic [EP_W-1:0]               prod_env_ff;
   logic [POS_W-1:0]              pos_ff;
   logic [ENV_W-1:0]              gain_ff;

   logic signed [SUM_W-1:0] sum_ab, thr_ext;
   logic                    trig, accept, active_in, fade, first;
   logic [POS_W-1:0]        pos_eff;
   logic [IDX_W-1:0]        idx_raw, i0_wide;
   logic [AW-1:0]           i0, i1;
   logic [ENV_W:0]          env_sh;
   logic [ENV_W-1:0]        gnew;

   assign sum_ab    = SUM_W'(req_left_sample) + SUM_W'(req_right_sample);
   assign thr_ext   = $signed(SUM_W'(cfg.threshold));
   assign trig      = (sum_ab > thr_ext) && (CMP_W'(pos_ff) > CMP_W'(cfg.min_chunk));
   assign pos_eff   = trig ? '0 : pos_ff;
   assign active_in = pos_eff < POS_W'(SLICE_DEPTH);
   assign accept    = req_valid && req_ready;

   assign idx_raw = prod_idx_ff[PROD_W-1:FRAC_W];
   assign i0_wide = (idx_raw >= IDX_W'(SLICE_DEPTH)) ? idx_raw - IDX_W'(SLICE_DEPTH) : idx_raw;
   assign i0      = i0_wide[AW-1:0];
   assign i1      = (i0 == AW'(SLICE_DEPTH - 1)) ? '0 : i0 + 1'b1;
   assign env_sh  = prod_env_ff[EP_W-1:ENV_SHIFT];
   assign gnew    = !active_ff ? '0 : (env_sh[ENV_W] ? '1 : env_sh[ENV_W-1:0]);
   assign fade    = active_ff && (p_ff < FADE_LENGTH);
   assign first   = active_ff && (p_ff == '0);
   assign q_data  = {a_ff, b_ff, p_ff, active_ff, fade, first, i0, i1,
                     prod_idx_ff[FRAC_W-1:0], gnew};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) state_in = F_MUL;
         end
         F_MUL:  state_in = F_PUSH;
         F_PUSH: begin
            if (!q_stat.full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == F_IDLE) && !clr_busy;
      q_push    = (state_ff == F_PUSH) && !q_stat.full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pos_ff   <= POS_W'(SLICE_DEPTH + 1);
         gain_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (q_push) begin
            pos_ff  <= active_ff ? POS_W'(p_ff) + 1'b1 : pos_ff;
            gain_ff <= gnew;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff      <= req_left_sample;
         b_ff      <= req_right_sample;
         p_ff      <= pos_eff[AW-1:0];
         active_ff <= active_in;
         gbase_ff  <= trig ? ENV_ONE : gain_ff;
      end
      if (state_ff == F_MUL) begin
         prod_idx_ff <= PROD_W'(p_ff) * PROD_W'(cfg.pitch_ratio);
         prod_env_ff <= EP_W'(gbase_ff) * EP_W'(cfg.decay_factor);
      end
   end

endmodule

### rtl/ttsr_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the front end and the back end
module ttsr_queue #(
   parameter int WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       pop_data,
   output ttsr_pkg::q_status_type q_stat
);
   import ttsr_pkg::*;

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   assign q_stat.full  = count_ff == 2'd2;
   assign q_stat.empty = count_ff == 2'd0;
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### rtl/ttsr_back.sv
`timescale 1ns / 1ps
// Back end: slice store, fade, interpolation, envelope scaling and output mix
module ttsr_back #(
   parameter int SLICE_DEPTH = 32768,
   parameter int FADE_LENGTH = 80,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ttsr_pkg::cfg_type             cfg,
   input  ttsr_pkg::q_status_type        q_stat,
   output logic                          q_pop,
   input  logic [2*SAMPLE_BITS+3*$clog2(SLICE_DEPTH)+3+16+32-1:0] q_data,
   output logic                          clr_busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out
);
   import ttsr_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int SW    = SB + 1;
   localparam int AW    = $clog2(SLICE_DEPTH);
   localparam int QW    = 2 * SB + 3 * AW + 3 + FRAC_W + ENV_W;
   localparam int FW    = $clog2(FADE_LENGTH + 1);
   localparam int PF_W  = (FW > AW) ? FW : AW;
   localparam int MAG_W = SB + FW;
   localparam int NUM_W = SW + PF_W + 2;
   localparam int RS    = MAG_W + FW;
   localparam int RCP_W = MAG_W + 2;
   localparam int QP_W  = MAG_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << RS) / FADE_LENGTH + 1);
   localparam int WF_W  = FRAC_W + 1;
   localparam int IS_W  = SW + WF_W + 2;
   localparam int MX_W  = SW + ENV_W + 1;
   localparam int WL_W  = MX_W - ENV_SHIFT;
   localparam int WM_W  = GAIN_W + 2;
   localparam int TD_W  = SB + GAIN_W + 1;
   localparam int TW_W  = WL_W + WM_W;
   localparam int OW    = TW_W + 1;
   localparam logic signed [OW-1:0] SAT_HI = {{(OW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
   localparam logic signed [OW-1:0] SAT_LO = ~SAT_HI;

   b_state_type state_ff, state_in;

   logic signed [SW-1:0] mem_l [SLICE_DEPTH];
   logic signed [SB-1:0] mem_r [SLICE_DEPTH];
   logic [AW-1:0]        mem_addr;
   logic                 we_l, we_r;
   logic signed [SW-1:0] wd_l;
   logic signed [SB-1:0] wd_r;
   logic signed [SW-1:0] rd_l_ff;
   logic signed [SB-1:0] rd_r_ff;

   logic [QW-1:0]        cur_ff;
   logic signed [SB-1:0] cur_a, cur_b;
   logic [AW-1:0]        cur_p, cur_i0, cur_i1;
   logic                 cur_active, cur_fade, cur_first;
   logic [FRAC_W-1:0]    cur_frac;
   logic [ENV_W-1:0]     cur_gain;

   logic [AW-1:0]        clr_addr_ff;
   logic signed [SW-1:0] s0_l_ff, s0_r_ff, s1_l_ff, s1_r_ff;
   logic signed [SW-1:0] held_l_ff, held_r_ff, last_l_ff, last_r_ff;
   logic [MAG_W-1:0]     dvd_l_ff, dvd_r_ff;
   logic [MAG_W-1:0]     quo_l_ff, quo_r_ff;
   logic                 neg_l_ff, neg_r_ff;
   logic signed [WL_W-1:0] wl_ff, wr_ff;
   logic signed [TD_W-1:0] td_l_ff, td_r_ff;
   logic signed [TW_W-1:0] tw_l_ff, tw_r_ff;
   logic                   rsp_valid_ff;
   logic signed [SB-1:0]   rsp_l_ff, rsp_r_ff;

   logic                   hq, out_free;
   logic [PF_W-1:0]        w_new, w_old;
   logic signed [SW-1:0]   held_l_sel, held_r_sel;
   logic signed [NUM_W-1:0] pl_old, pl_new, pr_old, pr_new, num_l, num_r, abs_l, abs_r;
   logic [QP_W-1:0]        qp_l, qp_r;
   logic signed [MAG_W:0]  qx_l, qx_r;
   logic [WF_W-1:0]        wf0, wf1;
   logic signed [IS_W-1:0] ip_l, ip_r;
   logic signed [MX_W-1:0] mw_l, mw_r;
   logic [GAIN_W:0]        wmul;
   logic signed [WL_W-1:0] wr_use;
   logic signed [OW-1:0]   sum_l, sum_r;

   function automatic logic signed [SB-1:0] sat_lane(input logic signed [OW-1:0] v);
      logic signed [OW-1:0] s;
      s = v >>> OUT_SHIFT;
      if (s > SAT_HI) return SAT_HI[SB-1:0];
      if (s < SAT_LO) return SAT_LO[SB-1:0];
      return s[SB-1:0];
   endfunction

   assign {cur_a, cur_b, cur_p, cur_active, cur_fade, cur_first, cur_i0, cur_i1,
           cur_frac, cur_gain} = cur_ff;

   assign hq       = cfg.high_quality;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign w_new      = PF_W'(cur_p);
   assign w_old      = PF_W'(FADE_LENGTH) - w_new;
   assign held_l_sel = cur_first ? last_l_ff : held_l_ff;
   assign held_r_sel = (cur_first && hq) ? last_r_ff : held_r_ff;
   assign pl_old     = held_l_sel * $signed({1'b0, w_old});
   assign pl_new     = s0_l_ff * $signed({1'b0, w_new});
   assign pr_old     = held_r_sel * $signed({1'b0, w_old});
   assign pr_new     = s0_r_ff * $signed({1'b0, w_new});
   assign num_l      = pl_old + pl_new;
   assign num_r      = pr_old + pr_new;
   assign abs_l      = num_l[NUM_W-1] ? -num_l : num_l;
   assign abs_r      = num_r[NUM_W-1] ? -num_r : num_r;

   assign qp_l = QP_W'(dvd_l_ff) * QP_W'(RCP);
   assign qp_r = QP_W'(dvd_r_ff) * QP_W'(RCP);
   assign qx_l = neg_l_ff ? -$signed({1'b0, quo_l_ff}) : $signed({1'b0, quo_l_ff});
   assign qx_r = neg_r_ff ? -$signed({1'b0, quo_r_ff}) : $signed({1'b0, quo_r_ff});

   assign wf1  = WF_W'(cur_frac);
   assign wf0  = WF_W'(2 ** FRAC_W) - wf1;
   assign ip_l = s0_l_ff * $signed({1'b0, wf0}) + s1_l_ff * $signed({1'b0, wf1});
   assign ip_r = s0_r_ff * $signed({1'b0, wf0}) + s1_r_ff * $signed({1'b0, wf1});

   assign mw_l   = last_l_ff * $signed({1'b0, cur_gain});
   assign mw_r   = last_r_ff * $signed({1'b0, cur_gain});
   assign wmul   = hq ? {cfg.wet_gain, 1'b0} : {1'b0, cfg.wet_gain};
   assign wr_use = hq ? wr_ff : wl_ff;
   assign sum_l  = td_l_ff + tw_l_ff;
   assign sum_r  = td_r_ff + tw_r_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_l_ff;
   assign rsp_right_out = rsp_r_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR: begin
            if (clr_addr_ff == AW'(SLICE_DEPTH - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (!q_stat.empty) state_in = B_WRITE;
         end
         B_WRITE: state_in = cur_active ? B_RD0 : B_MIX;
         B_RD0:   state_in = B_RD1;
         B_RD1:   state_in = B_RD2;
         B_RD2: begin
            priority if (cur_fade) state_in = B_FADE;
            else if (hq) state_in = B_INTERP;
            else state_in = B_MIX;
         end
         B_FADE:   state_in = B_DIV;
         B_DIV:    state_in = B_FDONE;
         B_FDONE:  state_in = B_MIX;
         B_INTERP: state_in = B_MIX;
         B_MIX:    state_in = B_SCALE;
         B_SCALE:  state_in = B_OUT;
         B_OUT: begin
            if (out_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      clr_busy = state_ff == B_CLEAR;
      q_pop    = (state_ff == B_IDLE) && !q_stat.empty;
      we_l     = 1'b0;
      we_r     = 1'b0;
      wd_l     = '0;
      wd_r     = '0;
      mem_addr = cur_i1;
      unique case (state_ff)
         B_CLEAR: begin
            mem_addr = clr_addr_ff;
            we_l     = 1'b1;
            we_r     = 1'b1;
         end
         B_WRITE: begin
            mem_addr = cur_p;
            we_l     = cur_active;
            we_r     = cur_active && hq;
            wd_l     = hq ? SW'(cur_a) : SW'(cur_a) + SW'(cur_b);
            wd_r     = cur_b;
         end
         B_RD0: mem_addr = cur_i0;
         default: mem_addr = cur_i1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_l) mem_l[mem_addr] <= wd_l;
      if (we_r) mem_r[mem_addr] <= wd_r;
      rd_l_ff <= mem_l[mem_addr];
      rd_r_ff <= mem_r[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_addr_ff  <= '0;
         held_l_ff    <= '0;
         held_r_ff    <= '0;
         last_l_ff    <= '0;
         last_r_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) clr_addr_ff <= clr_addr_ff + 1'b1;
         if (state_ff == B_FADE) begin
            held_l_ff <= held_l_sel;
            held_r_ff <= held_r_sel;
         end
         if (state_ff == B_RD2 && !cur_fade && !hq) last_l_ff <= s0_l_ff;
         if (state_ff == B_INTERP) begin
            last_l_ff <= ip_l[SW+FRAC_W-1:FRAC_W];
            last_r_ff <= ip_r[SW+FRAC_W-1:FRAC_W];
         end
         if (state_ff == B_FDONE) begin
            last_l_ff <= qx_l[SW-1:0];
            if (hq) last_r_ff <= qx_r[SW-1:0];
         end
         if (state_ff == B_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_data;
      if (state_ff == B_RD1) begin
         s0_l_ff <= rd_l_ff;
         s0_r_ff <= SW'(rd_r_ff);
      end
      if (state_ff == B_RD2) begin
         s1_l_ff <= rd_l_ff;
         s1_r_ff <= SW'(rd_r_ff);
      end
      if (state_ff == B_FADE) begin
         dvd_l_ff <= abs_l[MAG_W-1:0];
         dvd_r_ff <= abs_r[MAG_W-1:0];
         neg_l_ff <= num_l[NUM_W-1];
         neg_r_ff <= num_r[NUM_W-1];
      end
      if (state_ff == B_DIV) begin
         quo_l_ff <= MAG_W'(qp_l[QP_W-1:RS]);
         quo_r_ff <= MAG_W'(qp_r[QP_W-1:RS]);
      end
      if (state_ff == B_MIX) begin
         wl_ff <= mw_l[MX_W-1:ENV_SHIFT];
         wr_ff <= mw_r[MX_W-1:ENV_SHIFT];
      end
      if (state_ff == B_SCALE) begin
         td_l_ff <= cur_a * $signed({1'b0, cfg.dry_gain});
         td_r_ff <= cur_b * $signed({1'b0, cfg.dry_gain});
         tw_l_ff <= wl_ff * $signed({1'b0, wmul});
         tw_r_ff <= wr_use * $signed({1'b0, wmul});
      end
      if (state_ff == B_OUT && out_free) begin
         rsp_l_ff <= sat_lane(sum_l);
         rsp_r_ff <= sat_lane(sum_r);
      end
   end

endmodule

### rtl/transient_triggered_slice_repitch_unit.sv
`timescale 1ns / 1ps
// Top level of the transient triggered slice repitch unit
//
//   channel | ports            | direction | moves
//   req     | req_valid/ready  | in        | one stereo sample item
//   rsp     | rsp_valid/ready  | out       | one mixed stereo item
//   csr     | csr_valid/ready  | in        | register index and data
//
// Front end steps items through idle, multiply and push; the back end sets the rate:
// write, three reads, fade or interpolation if due, mix, scale and output (a muted
// item skips the reads), bounded by the single slice store port and the reciprocal
// multiply of the fade. After reset a clearing pass zeroes the store; req_ready
// stays low until it ends. A two-entry queue and the output register decouple stalls.
module transient_triggered_slice_repitch_unit #(
   parameter int SLICE_DEPTH = 32768,
   parameter int FADE_LENGTH = 80,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0]       req_right_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]       rsp_right_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ttsr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ttsr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ttsr_pkg::*;

   localparam int AW = $clog2(SLICE_DEPTH);
   localparam int QW = 2 * SAMPLE_BITS + 3 * AW + 3 + FRAC_W + ENV_W;

   cfg_type      cfg_ff;
   q_status_type q_stat;
   logic         q_push, q_pop, clr_busy;
   logic [QW-1:0] q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold    <= THRESHOLD_RESET;
         cfg_ff.decay_factor <= DECAY_RESET;
         cfg_ff.pitch_ratio  <= RATIO_RESET;
         cfg_ff.wet_gain     <= WET_RESET;
         cfg_ff.dry_gain     <= DRY_RESET;
         cfg_ff.min_chunk    <= CHUNK_RESET;
         cfg_ff.high_quality <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD:    cfg_ff.threshold    <= csr_data[THRESHOLD_W-1:0];
            CSR_DECAY_FACTOR: cfg_ff.decay_factor <= csr_data[DECAY_W-1:0];
            CSR_PITCH_RATIO:  cfg_ff.pitch_ratio  <= csr_data[RATIO_W-1:0];
            CSR_WET_GAIN:     cfg_ff.wet_gain     <= csr_data[GAIN_W-1:0];
            CSR_DRY_GAIN:     cfg_ff.dry_gain     <= csr_data[GAIN_W-1:0];
            CSR_MIN_CHUNK:    cfg_ff.min_chunk    <= csr_data[CHUNK_W-1:0];
            CSR_HIGH_QUALITY: cfg_ff.high_quality <= csr_data[0];
            default: ;
         endcase
      end
   end

   ttsr_front #(
      .SLICE_DEPTH(SLICE_DEPTH),
      .FADE_LENGTH(FADE_LENGTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .clr_busy        (clr_busy),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_left_sample (req_left_sample),
      .req_right_sample(req_right_sample),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_data          (q_wdata)
   );

   ttsr_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_wdata),
      .pop      (q_pop),
      .pop_data (q_rdata),
      .q_stat   (q_stat)
   );

   ttsr_back #(
      .SLICE_DEPTH(SLICE_DEPTH),
      .FADE_LENGTH(FADE_LENGTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_stat       (q_stat),
      .q_pop        (q_pop),
      .q_data       (q_rdata),
      .clr_busy     (clr_busy),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_left_out (rsp_left_out),
      .rsp_right_out(rsp_right_out)
   );

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_ready) else $error("item accepted during store clear");

   a_clear_queue_empty: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> q_stat.empty) else $error("queue holds an item during store clear");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_push) else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty) else $error("pop from empty queue");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the transient triggered slice repitch unit
module testbench;
   import ttsr_pkg::*;

   localparam int DEPTH      = 32768;
   localparam int FADE       = 80;
   localparam int SBITS      = 24;
   localparam int N_RANDOM   = 1130;
   localparam int CYCLE_CAP  = 1500000;
   localparam int DRAIN_WAIT = 200;

   typedef struct {
      logic signed [SBITS-1:0] left;
      logic signed [SBITS-1:0] right;
   } stereo_type;

   typedef struct {
      logic signed [SBITS-1:0] left;
      logic signed [SBITS-1:0] right;
      bit                      typed;
      logic signed [SBITS-1:0] exp_left;
      logic signed [SBITS-1:0] exp_right;
   } directed_row_type;

   typedef struct {
      logic [THRESHOLD_W-1:0] threshold;
      logic [DECAY_W-1:0]     decay;
      logic [RATIO_W-1:0]     ratio;
      logic [GAIN_W-1:0]      wet;
      logic [GAIN_W-1:0]      dry;
      logic [CHUNK_W-1:0]     chunk;
      logic                   hq;
   } setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SBITS-1:0] req_left_sample = '0;
   logic signed [SBITS-1:0] req_right_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SBITS-1:0] rsp_left_out;
   logic signed [SBITS-1:0] rsp_right_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   transient_triggered_slice_repitch_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_left_sample(req_left_sample), .req_right_sample(req_right_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_left_out(rsp_left_out), .rsp_right_out(rsp_right_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   int          slice_l [DEPTH];
   int          slice_r [DEPTH];
   longint      play_pos;
   longint      envelope;
   longint      held_l, held_r, wet_l, wet_r;
   setting_type cfg;

   stereo_type  mix_expected[$];
   int          errors = 0;
   int          cycles = 0;
   bit          calm = 1'b0;
   bit          press_req = 1'b0;
   int          hold_left = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   function automatic logic signed [SBITS-1:0] clip(input longint v);
      longint lim;
      lim = longint'(1) << (SBITS - 1);
      if (v >= lim) v = lim - 1;
      if (v < -lim) v = -lim;
      return v[SBITS-1:0];
   endfunction

   function automatic stereo_type repitch_predict(input logic signed [SBITS-1:0] l_in,
                                                  input logic signed [SBITS-1:0] r_in);
      longint a, b, p, prod, frac, xl, xr, g, wl, wr, wmul;
      int i0, i1;
      stereo_type res;
      a = l_in;
      b = r_in;
      if (a + b > longint'(cfg.threshold) && play_pos > longint'(cfg.chunk)) begin
         envelope = longint'(ENV_ONE);
         play_pos = 0;
      end
      if (play_pos < DEPTH) begin
         p = play_pos;
         prod = p * longint'(cfg.ratio);
         i0 = int'((prod >> FRAC_W) % DEPTH);
         frac = prod & 64'hFFFF;
         xr = wet_r;
         if (cfg.hq) begin
            slice_l[p] = int'(a);
            slice_r[p] = int'(b);
         end else begin
            slice_l[p] = int'(a + b);
         end
         if (p < FADE) begin
            if (p == 0) begin
               held_l = wet_l;
               if (cfg.hq) held_r = wet_r;
            end
            xl = (held_l * (FADE - p) + longint'(slice_l[i0]) * p) / FADE;
            if (cfg.hq) xr = (held_r * (FADE - p) + longint'(slice_r[i0]) * p) / FADE;
         end else if (cfg.hq) begin
            i1 = (i0 + 1) % DEPTH;
            xl = (longint'(slice_l[i0]) * (65536 - frac) + longint'(slice_l[i1]) * frac) >>> 16;
            xr = (longint'(slice_r[i0]) * (65536 - frac) + longint'(slice_r[i1]) * frac) >>> 16;
         end else begin
            xl = slice_l[i0];
         end
         wet_l = xl;
         if (cfg.hq) wet_r = xr;
         play_pos = p + 1;
         g = (envelope * longint'(cfg.decay)) >> ENV_SHIFT;
         envelope = (g > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : g;
      end else begin
         envelope = 0;
      end
      wl = (wet_l * envelope) >>> ENV_SHIFT;
      wr = cfg.hq ? ((wet_r * envelope) >>> ENV_SHIFT) : wl;
      wmul = longint'(cfg.wet) * (cfg.hq ? 2 : 1);
      res.left = clip((a * longint'(cfg.dry) + wl * wmul) >>> OUT_SHIFT);
      res.right = clip((b * longint'(cfg.dry) + wr * wmul) >>> OUT_SHIFT);
      return res;
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_THRESHOLD:    cfg.threshold = value[THRESHOLD_W-1:0];
         CSR_DECAY_FACTOR: cfg.decay = value[DECAY_W-1:0];
         CSR_PITCH_RATIO:  cfg.ratio = value[RATIO_W-1:0];
         CSR_WET_GAIN:     cfg.wet = value[GAIN_W-1:0];
         CSR_DRY_GAIN:     cfg.dry = value[GAIN_W-1:0];
         CSR_MIN_CHUNK:    cfg.chunk = value[CHUNK_W-1:0];
         CSR_HIGH_QUALITY: cfg.hq = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input setting_type s);
      csr_write(CSR_THRESHOLD, 31'(s.threshold));
      csr_write(CSR_DECAY_FACTOR, 31'(s.decay));
      csr_write(CSR_PITCH_RATIO, 31'(s.ratio));
      csr_write(CSR_WET_GAIN, 31'(s.wet));
      csr_write(CSR_DRY_GAIN, 31'(s.dry));
      csr_write(CSR_MIN_CHUNK, 31'(s.chunk));
      csr_write(CSR_HIGH_QUALITY, 31'(s.hq));
      csr_valid <= 1'b0;
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_sample(input logic signed [SBITS-1:0] l, input logic signed [SBITS-1:0] r,
                              input bit typed, input logic signed [SBITS-1:0] el,
                              input logic signed [SBITS-1:0] er);
      stereo_type res;
      req_valid <= 1'b1;
      req_left_sample <= l;
      req_right_sample <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      res = repitch_predict(l, r);
      if (typed) begin
         res.left = el;
         res.right = er;
      end
      mix_expected.push_back(res);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (mix_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic signed [SBITS-1:0] rand_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      if (r < 40) return SBITS'($urandom);
      return SBITS'($signed(20'($urandom)));
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("[transient_triggered_slice_repitch_unit] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (press_req && hold_left == 0) begin
         press_req <= 1'b0;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 20);
      end
   end

   always @(posedge clock) begin
      stereo_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mix_expected.size() == 0) begin
            report_mismatch("unexpected item", rsp_left_out, 0);
         end else begin
            want = mix_expected.pop_front();
            if (rsp_left_out !== want.left) report_mismatch("left_out", rsp_left_out, want.left);
            if (rsp_right_out !== want.right)
               report_mismatch("right_out", rsp_right_out, want.right);
         end
      end
   end

   initial begin
      directed_row_type rows[$];
      setting_type      phases[$];
      int               per_phase, n, r;
      logic signed [SBITS-1:0] l, rr;

      rows = '{
         '{24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
         '{24'sh800000, 24'sh800000, 1'b1, 24'sd0, 24'sd0},
         '{24'sd100, 24'sd200, 1'b1, 24'sd0, 24'sd0},
         '{24'sh7FFFFF, 24'sh800000, 1'b1, 24'sd0, 24'sd0},
         '{24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 24'sd0, 24'sd0},
         '{24'sh800000, 24'sh800000, 1'b0, 24'sd0, 24'sd0},
         '{24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 24'sd0, 24'sd0},
         '{24'sh000001, 24'shFFFFFF, 1'b0, 24'sd0, 24'sd0},
         '{24'sh555555, 24'shAAAAAA, 1'b0, 24'sd0, 24'sd0},
         '{24'shAAAAAA, 24'sh555555, 1'b0, 24'sd0, 24'sd0},
         '{24'sh400000, 24'sh400000, 1'b0, 24'sd0, 24'sd0},
         '{24'sh800000, 24'sh7FFFFF, 1'b0, 24'sd0, 24'sd0},
         '{24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0}
      };
      phases = '{
         '{24'd1000000, 31'h4000_0000, 17'd65536, 16'd32768, 16'd16384, 15'd0, 1'b1},
         '{24'd0, 31'h3FF0_0000, 17'd16384, 16'd65535, 16'd32768, 15'd40, 1'b0},
         '{24'd4000000, 31'h7FFF_FFFF, 17'd40000, 16'd16384, 16'd0, 15'd150, 1'b1},
         '{24'hFFFFFF, 31'd0, 17'd131071, 16'd0, 16'd65535, 15'd32767, 1'b0},
         '{24'd2000000, 31'h3FFF_0000, 17'd49152, 16'd32768, 16'd8192, 15'd90, 1'b0},
         '{24'd500000, 31'h4100_0000, 17'd65535, 16'd20000, 16'd32768, 15'd10, 1'b1}
      };

      cfg = '{THRESHOLD_RESET, DECAY_RESET, RATIO_RESET, WET_RESET, DRY_RESET, CHUNK_RESET, 1'b0};
      play_pos = DEPTH + 1;
      envelope = 0;
      held_l = 0; held_r = 0; wet_l = 0; wet_r = 0;
      for (int i = 0; i < DEPTH; i++) begin
         slice_l[i] = 0;
         slice_r[i] = 0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         idle_gap(($urandom_range(0, 99) < 20) ? $urandom_range(1, 4) : 0);
         send_sample(rows[i].left, rows[i].right, rows[i].typed, rows[i].exp_left,
                     rows[i].exp_right);
      end

      per_phase = N_RANDOM / phases.size();
      n = 0;
      foreach (phases[k]) begin
         drain();
         apply_setting(phases[k]);
         for (int j = 0; j < per_phase; j++) begin
            calm = (n >= 400 && n < 600);
            if (n == 250) press_req = 1'b1;
            if (!calm) idle_gap(($urandom_range(0, 99) < 20) ? $urandom_range(1, 6) : 0);
            r = $urandom_range(0, 99);
            if (r < 8) begin
               l = SBITS'($urandom_range(3000000, 8388607));
               rr = SBITS'($urandom_range(3000000, 8388607));
            end else begin
               l = rand_sample();
               rr = rand_sample();
            end
            send_sample(l, rr, 1'b0, '0, '0);
            n++;
         end
      end
      calm = 1'b0;
      drain();

      if (errors == 0) begin
         $display("[transient_triggered_slice_repitch_unit] OK");
      end else begin
         $display("[transient_triggered_slice_repitch_unit] ERROR");
      end
      $finish;
   end

endmodule

### transient_triggered_slice_repitch_unit.f
rtl/ttsr_pkg.sv
rtl/ttsr_front.sv
rtl/ttsr_queue.sv
rtl/ttsr_back.sv
rtl/transient_triggered_slice_repitch_unit.sv
tb/sv/testbench.sv
